>>> src/essb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package essb_pkg;

  localparam int ORDER_BITS = 16;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_WAKE   = 2'd1,
    CMD_SLEEP  = 2'd2,
    CMD_SCHED  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_IN_USE     = 2'd1,
    ST_NOT_QUEUED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_SCAN,
    S_WB
  } state_e;

  // per-cell control: rotate the ring, or write selected fields in place
  typedef struct packed {
    logic shift;
    logic we_valid;
    logic we_pred;
    logic we_qs;
    logic we_cs;
    logic we_order;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> src/essb_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface essb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  task_slot;
  logic [31:0] now;
  modport source (output valid, cmd, task_slot, now, input ready);
  modport sink (input valid, cmd, task_slot, now, output ready);
endinterface

interface essb_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] run_slot;
  logic       switched;
  logic [1:0] status;
  logic [4:0] queued_count;
  modport source (output valid, run_slot, switched, status, queued_count, input ready);
  modport sink (input valid, run_slot, switched, status, queued_count, output ready);
endinterface
`default_nettype wire

>>> src/essb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module essb_cell #(
  parameter int TW = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         rst_valid_i,
  input  essb_pkg::cell_ctl_t         ctl_i,
  input  wire                         nb_valid_i,
  input  wire [TW-1:0]                nb_pred_i,
  input  wire [TW-1:0]                nb_qs_i,
  input  wire [TW-1:0]                nb_cs_i,
  input  wire [essb_pkg::ORDER_BITS-1:0] nb_order_i,
  input  wire                         wr_valid_i,
  input  wire [TW-1:0]                wr_pred_i,
  input  wire [TW-1:0]                wr_qs_i,
  input  wire [TW-1:0]                wr_cs_i,
  input  wire [essb_pkg::ORDER_BITS-1:0] wr_order_i,
  output logic                        valid_o,
  output logic [TW-1:0]               pred_o,
  output logic [TW-1:0]               qs_o,
  output logic [TW-1:0]               cs_o,
  output logic [essb_pkg::ORDER_BITS-1:0] order_o
);
  import essb_pkg::*;

  logic                  valid_q;
  logic [TW-1:0]         pred_q, qs_q, cs_q;
  logic [ORDER_BITS-1:0] order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= rst_valid_i;
      pred_q  <= '0;
      qs_q    <= '0;
      cs_q    <= '0;
      order_q <= '0;
    end else if (ctl_i.shift) begin
      valid_q <= nb_valid_i;
      pred_q  <= nb_pred_i;
      qs_q    <= nb_qs_i;
      cs_q    <= nb_cs_i;
      order_q <= nb_order_i;
    end else begin
      if (ctl_i.we_valid) valid_q <= wr_valid_i;
      if (ctl_i.we_pred)  pred_q  <= wr_pred_i;
      if (ctl_i.we_qs)    qs_q    <= wr_qs_i;
      if (ctl_i.we_cs)    cs_q    <= wr_cs_i;
      if (ctl_i.we_order) order_q <= wr_order_i;
    end
  end

  assign valid_o = valid_q;
  assign pred_o  = pred_q;
  assign qs_o    = qs_q;
  assign cs_o    = cs_q;
  assign order_o = order_q;

endmodule
`default_nettype wire

>>> src/essb_div3.sv
`timescale 1ns / 1ps
`default_nettype none
module essb_div3 #(
  parameter int XW = 34
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire [XW-1:0]  x_i,
  output logic          busy_o,
  output logic [XW-1:0] q_o
);
  import essb_pkg::*;

  localparam int H = XW / 2;
  // ceil(2^(XW+1)/3); XW+1 is odd, so the reciprocal is exact for every XW-bit x
  localparam logic [XW-1:0] RECIP = XW'(((64'd1 << (XW + 1)) + 64'd1) / 64'd3);

  logic            busy_q;
  logic [1:0]      step_q;
  logic [XW-1:0]   x_q;
  logic [2*XW-1:0] acc_q;
  logic [H-1:0]    xa, mb;
  logic [XW-1:0]   prod;
  logic [2*XW-1:0] prod_x, part;

  // x * RECIP built from four half-width partial products, one per cycle
  always_comb begin
    xa     = step_q[1] ? x_q[XW-1:H] : x_q[H-1:0];
    mb     = step_q[0] ? RECIP[XW-1:H] : RECIP[H-1:0];
    prod   = {{H{1'b0}}, xa} * {{H{1'b0}}, mb};
    prod_x = {{XW{1'b0}}, prod};
    case (step_q)
      2'd0:    part = prod_x;
      2'd3:    part = prod_x << XW;
      default: part = prod_x << H;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd3) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + part;
    end
  end

  assign busy_o = busy_q;
  assign q_o    = {1'b0, acc_q[2*XW-1:XW+1]};

endmodule
`default_nettype wire

>>> src/expected_burst_task_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Shortest-expected-burst-first scheduler with aging. Each table slot lives in
// one cell of a ring; slot 0 is the seed task and is always queued. Create,
// wake and sleep items are latched on acceptance, then update the addressed
// cell. A schedule item with more than the seed queued sends the new burst
// prediction through a divide-by-3 unit that multiplies by a reciprocal in
// four half-width partial products, then rotates the ring once, feeding each
// record past a single registered comparator at its head (cross-multiply
// when the wait weighting bit is set, else prediction only). A schedule item
// with only the seed queued skips the divider and the ring. One item is in
// work at a time; the next is taken once the result has been handed off. The
// wait weighting bit is written through cfg_we_i/cfg_wdata_i and resets to 1.
module expected_burst_task_scheduler_top #(
  parameter int TASK_SLOTS = 16,
  parameter int TIME_BITS  = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire        cfg_wdata_i,
  essb_in_if.sink    in_i,
  essb_out_if.source out_o
);
  import essb_pkg::*;

  localparam int N  = TASK_SLOTS;
  localparam int TW = TIME_BITS;
  localparam int SW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int XW = ((TW + 3) / 2) * 2;
  localparam int PW = 2 * TW + 2;
  localparam int OB = ORDER_BITS;

  // ring of slot cells
  logic          c_valid [N];
  logic [TW-1:0] c_pred  [N];
  logic [TW-1:0] c_qs    [N];
  logic [TW-1:0] c_cs    [N];
  logic [OB-1:0] c_order [N];
  cell_ctl_t     ctl     [N];
  logic [N-1:0]  vmap;

  logic          wr_valid;
  logic [TW-1:0] wr_pred, wr_qs, wr_cs;
  logic [OB-1:0] wr_order;

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int NB = (i + 1) % N;
    essb_cell #(.TW(TW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rst_valid_i (i == 0),
      .ctl_i       (ctl[i]),
      .nb_valid_i  (c_valid[NB]),
      .nb_pred_i   (c_pred[NB]),
      .nb_qs_i     (c_qs[NB]),
      .nb_cs_i     (c_cs[NB]),
      .nb_order_i  (c_order[NB]),
      .wr_valid_i  (wr_valid),
      .wr_pred_i   (wr_pred),
      .wr_qs_i     (wr_qs),
      .wr_cs_i     (wr_cs),
      .wr_order_i  (wr_order),
      .valid_o     (c_valid[i]),
      .pred_o      (c_pred[i]),
      .qs_o        (c_qs[i]),
      .cs_o        (c_cs[i]),
      .order_o     (c_order[i])
    );
  end

  // control state
  state_e        state_q, state_d;
  logic          out_v_q, out_v_d;
  logic [SW-1:0] run_q, run_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [OB-1:0] ctr_q, ctr_d;
  logic          cw_q;
  logic [SW-1:0] k_q, k_d;
  logic          phase_q, phase_d;
  logic          have_q, have_d;

  // latched item and results
  cmd_e          cmd_q;
  logic          slot_ok_q;
  logic [SW-1:0] sidx_q;
  logic [TW-1:0] now_q;
  logic          sw_q, sw_d;
  status_e       st_q, st_d;

  // scan datapath
  logic [TW-1:0] charged_q;
  logic [SW-1:0] best_slot_q;
  logic [TW-1:0] best_pred_q, best_wait_q;
  logic [OB-1:0] best_age_q;
  logic          cand_ok_q;
  logic [SW-1:0] cand_slot_q;
  logic [TW-1:0] cand_pred_q, cand_wait_q;
  logic [OB-1:0] cand_age_q;
  logic [PW-1:0] pc_q, pb_q;

  // divider
  logic          div_start, div_busy;
  logic [XW-1:0] div_x, div_q;

  essb_div3 #(.XW(XW)) u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (div_x),
    .busy_o  (div_busy),
    .q_o     (div_q)
  );

  // input decode
  logic          in_acc;
  logic [31:0]   slot_w;
  logic [SW+3:0] slot_x;
  logic [TW+31:0] now_x;

  assign in_acc = in_i.valid && in_i.ready;
  assign slot_w = {28'd0, in_i.task_slot};
  assign slot_x = {{SW{1'b0}}, in_i.task_slot};
  assign now_x  = {{TW{1'b0}}, in_i.now};

  // one shared read port into the ring, valid while the ring is at home
  logic [SW-1:0] rd_addr;
  logic          rd_valid;
  logic [TW-1:0] rd_pred, rd_cs, burst;

  assign rd_addr  = (cmd_q == CMD_SCHED) ? run_q : sidx_q;
  assign rd_valid = c_valid[rd_addr];
  assign rd_pred  = c_pred[rd_addr];
  assign rd_cs    = c_cs[rd_addr];
  assign burst    = now_q - rd_cs;
  assign div_x    = {{(XW-TW-1){1'b0}}, burst, 1'b0} + {{(XW-TW){1'b0}}, rd_pred};

  // head of ring: candidate for the comparator
  logic          is_cur, cand_ok;
  logic [TW-1:0] cand_pred, cand_wait;
  logic [OB-1:0] cand_age;
  logic [TW:0]   a_cand, a_bwait, a_bpred, a_cwait;
  logic [PW-1:0] pc, pb;

  always_comb begin
    is_cur    = (k_q == run_q);
    cand_ok   = c_valid[0] && (k_q != '0);
    // the running task is seen with its charged prediction and no wait
    cand_pred = is_cur ? charged_q : c_pred[0];
    cand_wait = is_cur ? '0 : (now_q - c_qs[0]);
    cand_age  = ctr_q - c_order[0];
    a_cand    = {1'b0, cand_pred} + (TW+1)'(1);
    a_cwait   = {1'b0, cand_wait} + (TW+1)'(1);
    a_bpred   = {1'b0, best_pred_q} + (TW+1)'(1);
    a_bwait   = {1'b0, best_wait_q} + (TW+1)'(1);
    pc        = {{(TW+1){1'b0}}, a_cand} * {{(TW+1){1'b0}}, a_bwait};
    pb        = {{(TW+1){1'b0}}, a_bpred} * {{(TW+1){1'b0}}, a_cwait};
  end

  logic better, take;

  always_comb begin
    if (cw_q) begin
      better = (pc_q < pb_q) || ((pc_q == pb_q) && (cand_age_q < best_age_q));
    end else begin
      better = (cand_pred_q < best_pred_q) ||
               ((cand_pred_q == best_pred_q) && (cand_age_q < best_age_q));
    end
    take = (state_q == S_SCAN) && phase_q && cand_ok_q && (!have_q || better);
  end

  // next state and cell control
  cell_ctl_t     wa_ctl;
  logic          wa_en, wb_en, scan_shift;
  logic [SW-1:0] wa_idx, wb_idx;

  always_comb begin
    state_d    = state_q;
    out_v_d    = out_v_q;
    run_d      = run_q;
    cnt_d      = cnt_q;
    ctr_d      = ctr_q;
    k_d        = k_q;
    phase_d    = phase_q;
    have_d     = have_q;
    sw_d       = sw_q;
    st_d       = st_q;
    div_start  = 1'b0;
    wa_en      = 1'b0;
    wb_en      = 1'b0;
    wa_idx     = sidx_q;
    wb_idx     = best_slot_q;
    wa_ctl     = '0;
    scan_shift = 1'b0;
    wr_valid   = (cmd_q != CMD_SLEEP);
    wr_pred    = (state_q == S_WB) ? charged_q : '0;
    wr_cs      = (state_q == S_WB) ? now_q : '0;
    wr_qs      = now_q;
    wr_order   = ctr_q + OB'(1);

    if (out_v_q && out_o.ready) out_v_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_EXEC;
      end
      S_EXEC: begin
        sw_d    = 1'b0;
        st_d    = ST_OK;
        state_d = S_IDLE;
        out_v_d = 1'b1;
        case (cmd_q)
          CMD_CREATE, CMD_WAKE: begin
            if (!slot_ok_q) begin
              st_d = ST_NOT_QUEUED;
            end else if (rd_valid) begin
              st_d = ST_IN_USE;
            end else begin
              wa_en           = 1'b1;
              wa_ctl.we_valid = 1'b1;
              wa_ctl.we_qs    = 1'b1;
              wa_ctl.we_order = 1'b1;
              wa_ctl.we_pred  = (cmd_q == CMD_CREATE);
              wa_ctl.we_cs    = (cmd_q == CMD_CREATE);
              ctr_d           = ctr_q + OB'(1);
              cnt_d           = cnt_q + CW'(1);
            end
          end
          CMD_SLEEP: begin
            if (!slot_ok_q || (sidx_q == '0) || !rd_valid) begin
              st_d = ST_NOT_QUEUED;
            end else begin
              wa_en           = 1'b1;
              wa_ctl.we_valid = 1'b1;
              wa_ctl.we_qs    = 1'b1;
              cnt_d           = cnt_q - CW'(1);
            end
          end
          default: begin
            if (cnt_q < CW'(2)) begin
              // only the seed is queued: hand it the CPU, charge nobody
              sw_d  = (run_q != '0);
              run_d = '0;
            end else begin
              div_start = 1'b1;
              out_v_d   = out_v_q;
              state_d   = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (!div_busy) begin
          state_d = S_SCAN;
          k_d     = '0;
          phase_d = 1'b0;
          have_d  = 1'b0;
        end
      end
      S_SCAN: begin
        phase_d = !phase_q;
        if (phase_q) begin
          scan_shift = 1'b1;
          if (take) have_d = 1'b1;
          k_d = k_q + SW'(1);
          if (k_q == SW'(N - 1)) state_d = S_WB;
        end
      end
      S_WB: begin
        sw_d    = 1'b0;
        st_d    = ST_OK;
        state_d = S_IDLE;
        out_v_d = 1'b1;
        if (best_slot_q != run_q) begin
          // commit the charge to the old task, stamp the new one's start
          wa_en          = 1'b1;
          wa_idx         = run_q;
          wa_ctl.we_pred = 1'b1;
          wa_ctl.we_qs   = 1'b1;
          wb_en          = 1'b1;
          run_d          = best_slot_q;
          sw_d           = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctl[i]       = '0;
      ctl[i].shift = scan_shift;
      if (wa_en && (SW'(i) == wa_idx)) ctl[i] = wa_ctl;
      if (wb_en && (SW'(i) == wb_idx)) ctl[i].we_cs = 1'b1;
      vmap[i] = c_valid[i];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      run_q   <= '0;
      cnt_q   <= CW'(1);
      ctr_q   <= '0;
      cw_q    <= 1'b1;
      k_q     <= '0;
      phase_q <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      run_q   <= run_d;
      cnt_q   <= cnt_d;
      ctr_q   <= ctr_d;
      k_q     <= k_d;
      phase_q <= phase_d;
      have_q  <= have_d;
      if (cfg_we_i) cw_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sw_q <= sw_d;
    st_q <= st_d;
    if (in_acc) begin
      cmd_q     <= cmd_e'(in_i.cmd);
      slot_ok_q <= (slot_w < 32'(N));
      sidx_q    <= slot_x[SW-1:0];
      now_q     <= now_x[TW-1:0];
    end
    if ((state_q == S_DIV) && !div_busy) charged_q <= div_q[TW-1:0];
    if ((state_q == S_SCAN) && !phase_q) begin
      cand_ok_q   <= cand_ok;
      cand_slot_q <= k_q;
      cand_pred_q <= cand_pred;
      cand_wait_q <= cand_wait;
      cand_age_q  <= cand_age;
      pc_q        <= pc;
      pb_q        <= pb;
    end
    if (take) begin
      best_slot_q <= cand_slot_q;
      best_pred_q <= cand_pred_q;
      best_wait_q <= cand_wait_q;
      best_age_q  <= cand_age_q;
    end
  end

  // outputs
  logic [SW+3:0] run_x;
  logic [CW+4:0] cnt_x;

  assign run_x              = {4'd0, run_q};
  assign cnt_x              = {5'd0, cnt_q};
  assign in_i.ready         = (state_q == S_IDLE) && !out_v_q;
  assign out_o.valid        = out_v_q;
  assign out_o.run_slot     = run_x[3:0];
  assign out_o.switched     = sw_q;
  assign out_o.status       = st_q;
  assign out_o.queued_count = cnt_x[4:0];

  // a result waits only while the ring is at rest
  a_out_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (state_q == S_IDLE))
    else $error("result pending while busy");

  // seed task stays queued whenever the ring is at home
  a_seed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> c_valid[0])
    else $error("seed task lost");

  // queued counter tracks the valid bits
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (32'(cnt_q) == $countones(vmap)))
    else $error("queued count mismatch");

  // a schedule pick is never the seed when others are queued
  a_pick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (have_q && (best_slot_q != '0)))
    else $error("bad pick");

endmodule
`default_nettype wire
